// ----- design/two_pass_component_labeling_top_defines.svh -----
// Assertion macros used by the labeling block checker.
`ifndef TWO_PASS_COMPONENT_LABELING_TOP_DEFINES_SVH
`define TWO_PASS_COMPONENT_LABELING_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TPCL_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("labeling check failed");

// Checked on every clock edge, reset included.
`define TPCL_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("labeling reset check failed");

`endif

// ----- design/tpcl_pkg.sv -----
package tpcl_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_LABELS = 4096;

  localparam int DIM_W   = 9;
  localparam int VAL_W   = 13;
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 2;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int POS_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int LABEL_W = $clog2(MAX_LABELS);
  localparam int CNT_W   = $clog2(MAX_LABELS) + 1;

  localparam int FOREGROUND = 255;
  localparam int LABEL_BASE = 256;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MODE   = 2'd2;

  typedef struct packed {
    logic latch;
    logic lstart;
    logic img_sel_nb;
    logic par_sel_img;
    logic take_img;
    logic find;
    logic find_ld;
    logic adv;
    logic fresh;
    logic write_pix;
    logic out;
  } cmd_t;

  typedef struct packed {
    logic is_fg;
    logic frame_complete;
    logic img_is_label;
    logic find_done;
    logic nb_ok;
    logic nb_last;
  } stat_t;

endpackage

// ----- design/tpcl_ctrl.sv -----
module tpcl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            kind,
  input  tpcl_pkg::stat_t stat,
  output tpcl_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            result_valid
);
  import tpcl_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LSTART = 11'b00000000010,
    S_NREAD  = 11'b00000000100,
    S_NWAIT  = 11'b00000001000,
    S_FIND   = 11'b00000010000,
    S_FINAL  = 11'b00000100000,
    S_WRITE  = 11'b00001000000,
    S_RREAD  = 11'b00010000000,
    S_RWAIT  = 11'b00100000000,
    S_RFIND  = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (!kind) begin
            state_next = S_LSTART;
          end else if (stat.frame_complete) begin
            state_next = S_RREAD;
          end
        end
      end
      S_LSTART: begin
        cmd.lstart = 1'b1;
        state_next = stat.is_fg ? S_NREAD : S_WRITE;
      end
      S_NREAD: begin
        cmd.img_sel_nb = 1'b1;
        if (stat.nb_ok) begin
          state_next = S_NWAIT;
        end else begin
          cmd.adv = 1'b1;
          state_next = stat.nb_last ? S_FINAL : S_NREAD;
        end
      end
      S_NWAIT: begin
        cmd.take_img = 1'b1;
        cmd.par_sel_img = 1'b1;
        if (stat.img_is_label) begin
          state_next = S_FIND;
        end else begin
          cmd.adv = 1'b1;
          state_next = stat.nb_last ? S_FINAL : S_NREAD;
        end
      end
      S_FIND: begin
        cmd.find = 1'b1;
        cmd.find_ld = 1'b1;
        if (stat.find_done) begin
          cmd.adv = 1'b1;
          state_next = stat.nb_last ? S_FINAL : S_NREAD;
        end
      end
      S_FINAL: begin
        cmd.fresh = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_pix = 1'b1;
        state_next = S_IDLE;
      end
      S_RREAD: begin
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.take_img = 1'b1;
        cmd.par_sel_img = 1'b1;
        state_next = stat.img_is_label ? S_RFIND : S_OUT;
      end
      S_RFIND: begin
        cmd.find = 1'b1;
        if (stat.find_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.out = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign result_valid = (state == S_OUT);

endmodule

// ----- design/tpcl_datapath.sv -----
module tpcl_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tpcl_pkg::IDX_W-1:0] cfg_index,
  input  logic [tpcl_pkg::DIM_W-1:0] cfg_data,
  input  logic [tpcl_pkg::PIX_W-1:0] pixel_value,
  input  tpcl_pkg::cmd_t             cmd,
  output tpcl_pkg::stat_t            stat,
  output logic [tpcl_pkg::VAL_W-1:0] labeled_value,
  output logic                       last_pixel,
  output logic                       label_overflow
);
  import tpcl_pkg::*;

  logic [VAL_W-1:0]   label_image [MAX_WIDTH*MAX_HEIGHT];
  logic [LABEL_W-1:0] parent_table [MAX_LABELS];

  logic [DIM_W-1:0]   frame_width, frame_height;
  logic               conn_mode;
  logic [POS_W-1:0]   wpos, rpos;
  logic [COL_W-1:0]   wcol, rcol;
  logic [ROW_W-1:0]   wrow, rrow;
  logic               frame_complete, overflow_seen;
  logic [CNT_W-1:0]   label_count;
  logic [PIX_W-1:0]   pix;
  logic [1:0]         k;
  logic               have;
  logic [LABEL_W-1:0] root, x;
  logic [VAL_W-1:0]   img_rdata, result;
  logic [LABEL_W-1:0] par_rdata;

  logic [DIM_W-1:0]   eff_w, eff_h;
  logic               wlast_col, wlast_row, rlast_col, rlast_row;
  logic [POS_W-1:0]   up_addr, nb_addr, img_raddr;
  logic               nb_ok, nb_last;
  logic [VAL_W-1:0]   img_off, wr_val;
  logic [LABEL_W-1:0] img_lbl, par_raddr, par_waddr, par_wdata;
  logic               par_we, find_done, can_fresh;

  always_comb begin
    eff_w = frame_width;
    if (frame_width == '0) eff_w = DIM_W'(1);
    else if (frame_width > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    eff_h = frame_height;
    if (frame_height == '0) eff_h = DIM_W'(1);
    else if (frame_height > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
  end

  assign wlast_col = (DIM_W'(wcol) == eff_w - DIM_W'(1));
  assign wlast_row = (DIM_W'(wrow) == eff_h - DIM_W'(1));
  assign rlast_col = (DIM_W'(rcol) == eff_w - DIM_W'(1));
  assign rlast_row = (DIM_W'(rrow) == eff_h - DIM_W'(1));

  assign up_addr = wpos - POS_W'(eff_w);

  // Neighbor list: up then left in 4-connected mode; NW, N, NE, W otherwise.
  always_comb begin
    nb_addr = up_addr;
    nb_ok = 1'b0;
    nb_last = 1'b0;
    if (!conn_mode) begin
      nb_last = (k == 2'd1);
      if (k == 2'd0) begin
        nb_addr = up_addr;
        nb_ok = (wrow != '0);
      end else begin
        nb_addr = wpos - POS_W'(1);
        nb_ok = (wcol != '0);
      end
    end else begin
      nb_last = (k == 2'd3);
      unique case (k)
        2'd0: begin
          nb_addr = up_addr - POS_W'(1);
          nb_ok = (wrow != '0) && (wcol != '0);
        end
        2'd1: begin
          nb_addr = up_addr;
          nb_ok = (wrow != '0);
        end
        2'd2: begin
          nb_addr = up_addr + POS_W'(1);
          nb_ok = (wrow != '0) && !wlast_col;
        end
        default: begin
          nb_addr = wpos - POS_W'(1);
          nb_ok = (wcol != '0);
        end
      endcase
    end
  end

  assign img_raddr = cmd.img_sel_nb ? nb_addr : rpos;
  assign img_off   = img_rdata - VAL_W'(LABEL_BASE);
  assign img_lbl   = img_off[LABEL_W-1:0];
  assign par_raddr = cmd.par_sel_img ? img_lbl : par_rdata;
  assign find_done = (par_rdata >= x);
  assign can_fresh = (label_count < CNT_W'(MAX_LABELS));
  assign wr_val    = (pix == PIX_W'(FOREGROUND)) ?
                     (VAL_W'(LABEL_BASE) + VAL_W'(root)) : VAL_W'(pix);

  // One parent write: a link of two roots, or a new label pointing at itself.
  always_comb begin
    par_we = 1'b0;
    par_waddr = label_count[LABEL_W-1:0];
    par_wdata = label_count[LABEL_W-1:0];
    if (cmd.find_ld && find_done && have && (x != root)) begin
      par_we = 1'b1;
      par_waddr = (x > root) ? x : root;
      par_wdata = (x > root) ? root : x;
    end else if (cmd.fresh && !have && can_fresh) begin
      par_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    img_rdata <= label_image[img_raddr];
    if (cmd.write_pix) begin
      label_image[wpos] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    par_rdata <= parent_table[par_raddr];
    if (par_we) begin
      parent_table[par_waddr] <= par_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= DIM_W'(MAX_WIDTH);
      frame_height <= DIM_W'(MAX_HEIGHT);
      conn_mode <= 1'b0;
      wpos <= '0;
      wcol <= '0;
      wrow <= '0;
      rpos <= '0;
      rcol <= '0;
      rrow <= '0;
      frame_complete <= 1'b0;
      overflow_seen <= 1'b0;
      label_count <= '0;
      k <= '0;
      have <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index <= REG_MODE)) begin
        unique case (cfg_index)
          REG_WIDTH:  frame_width <= cfg_data;
          REG_HEIGHT: frame_height <= cfg_data;
          REG_MODE:   conn_mode <= cfg_data[0];
          default:    conn_mode <= conn_mode;
        endcase
        wpos <= '0;
        wcol <= '0;
        wrow <= '0;
        rpos <= '0;
        rcol <= '0;
        rrow <= '0;
        frame_complete <= 1'b0;
      end
      if (cmd.lstart) begin
        k <= '0;
        have <= 1'b0;
        if (wpos == '0) begin
          label_count <= '0;
          overflow_seen <= 1'b0;
          frame_complete <= 1'b0;
          rpos <= '0;
          rcol <= '0;
          rrow <= '0;
        end
      end
      if (cmd.adv) begin
        k <= k + 2'd1;
      end
      if (cmd.find_ld && find_done) begin
        if (!have) begin
          root <= x;
          have <= 1'b1;
        end else if (x < root) begin
          root <= x;
        end
      end
      if (cmd.fresh && !have) begin
        if (can_fresh) begin
          root <= label_count[LABEL_W-1:0];
          label_count <= label_count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
          root <= LABEL_W'(MAX_LABELS - 1);
        end
      end
      if (cmd.write_pix) begin
        if (wlast_col && wlast_row) begin
          wpos <= '0;
          wcol <= '0;
          wrow <= '0;
          frame_complete <= 1'b1;
        end else if (wlast_col) begin
          wpos <= wpos + POS_W'(1);
          wcol <= '0;
          wrow <= wrow + ROW_W'(1);
        end else begin
          wpos <= wpos + POS_W'(1);
          wcol <= wcol + COL_W'(1);
        end
      end
      if (cmd.out) begin
        if (rlast_col && rlast_row) begin
          rpos <= '0;
          rcol <= '0;
          rrow <= '0;
        end else if (rlast_col) begin
          rpos <= rpos + POS_W'(1);
          rcol <= '0;
          rrow <= rrow + ROW_W'(1);
        end else begin
          rpos <= rpos + POS_W'(1);
          rcol <= rcol + COL_W'(1);
        end
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pix <= pixel_value;
    end
    if (cmd.take_img) begin
      x <= img_lbl;
      result <= img_rdata;
    end
    if (cmd.find) begin
      if (!find_done) begin
        x <= par_rdata;
      end else if (!cmd.find_ld) begin
        result <= VAL_W'(LABEL_BASE) + VAL_W'(x);
      end
    end
  end

  assign stat.is_fg          = (pix == PIX_W'(FOREGROUND));
  assign stat.frame_complete = frame_complete;
  assign stat.img_is_label   = (img_rdata > VAL_W'(FOREGROUND));
  assign stat.find_done      = find_done;
  assign stat.nb_ok          = nb_ok;
  assign stat.nb_last        = nb_last;

  assign labeled_value  = result;
  assign last_pixel     = rlast_col && rlast_row;
  assign label_overflow = overflow_seen;

endmodule

// ----- design/two_pass_component_labeling_top.sv -----
// Connected-component labeling of one frame with a union-find label table.
// Input: start with kind and pixel_value is a transfer when busy is low.
// Kind 0 loads the next pixel in raster order; value 255 is foreground and
// takes a provisional label from its neighbors (up and left, or NW, N, NE
// and W when connectivity_mode is 1). Kind 1 reads out the next pixel once
// the frame is fully loaded; a readout before that gives no result.
// A result shows on labeled_value, last_pixel and label_overflow for the
// single cycle in which result_valid is high; it must be taken then.
// Sequence: a background pixel load goes through the start and write states.
// A foreground load reads each valid neighbor, walks its label to the root
// in the parent table, links the roots, takes a fresh label if none was
// found, then writes the pixel. A readout reads the pixel, walks a label to
// its root if the pixel is labeled, then shows the result; busy drops the cycle after the result.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 width,
// 1 height, 2 connectivity) and restarts the frame; write only while busy
// is low. Reset sets a 256 by 256, 4-connected frame and an empty label
// count; the image and parent memories need no clearing.
module two_pass_component_labeling_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tpcl_pkg::IDX_W-1:0] cfg_index,
  input  logic [tpcl_pkg::DIM_W-1:0] cfg_data,
  input  logic                       start,
  input  logic                       kind,
  input  logic [tpcl_pkg::PIX_W-1:0] pixel_value,
  output logic                       busy,
  output logic                       result_valid,
  output logic [tpcl_pkg::VAL_W-1:0] labeled_value,
  output logic                       last_pixel,
  output logic                       label_overflow
);
  import tpcl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tpcl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  tpcl_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_value    (pixel_value),
    .cmd            (cmd),
    .stat           (stat),
    .labeled_value  (labeled_value),
    .last_pixel     (last_pixel),
    .label_overflow (label_overflow)
  );

endmodule

// ----- design/tpcl_checker.sv -----
`include "two_pass_component_labeling_top_defines.svh"

module tpcl_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic kind,
  input logic busy,
  input logic result_valid
);

  // A result is a single-cycle strobe that ends the item's work.
  `TPCL_ASSERT(a_strobe_single, result_valid |=> !result_valid)
  `TPCL_ASSERT(a_strobe_busy, result_valid |-> busy)
  // A load accepted while the block is idle always makes it busy.
  `TPCL_ASSERT(a_load_busy, (start && !busy && !kind) |=> busy)
  `TPCL_ASSERT_RST(a_reset_idle, rst |=> (!busy && !result_valid))

endmodule

bind two_pass_component_labeling_top tpcl_checker u_tpcl_checker (.*);
